// ===== rtl/srst_pkg.sv =====
// ----------------------------------------------------------------------------
// srst_pkg
// types, widths and constants shared by the sprite line transform
// ----------------------------------------------------------------------------
package srst_pkg;

	localparam int COORD_W   = 8;
	localparam int SCREEN_W  = 12;
	localparam int ANGLE_W   = 16;
	localparam int SCALE_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 3'd3;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	localparam logic signed [SCREEN_W-1:0] SCREEN_MAX = 12'sd2047;
	localparam logic signed [SCREEN_W-1:0] SCREEN_MIN = -12'sd2048;

	// queue depths
	localparam int IN_DEPTH  = 4;
	localparam int OUT_DEPTH = 8;

	// cordic internals: q4.30, angles in 2^32 per turn
	localparam int CORDIC_FRAC = 30;
	localparam int CORDIC_GAIN = 652032874;
	localparam int ATAN_COUNT  = 24;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic                      final_line;
	} item_t;

	typedef struct packed {
		logic signed [SCREEN_W-1:0] screen_start_x;
		logic signed [SCREEN_W-1:0] screen_start_y;
		logic signed [SCREEN_W-1:0] screen_end_x;
		logic signed [SCREEN_W-1:0] screen_end_y;
		logic                       last_out;
	} result_t;

	// arctangent of 2^-i in 2^32 per turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/srst_fifo.sv =====
// ----------------------------------------------------------------------------
// srst_fifo
// small first-in first-out queue of words, head shown without a read cycle
// ----------------------------------------------------------------------------
module srst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/srst_cordic.sv =====
// ----------------------------------------------------------------------------
// srst_cordic
// rotation-mode cordic, one iteration a cycle, giving sine and cosine
// ----------------------------------------------------------------------------
module srst_cordic #(
	parameter int TRIG_FRAC_BITS = 14,
	parameter int CORDIC_STEPS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [srst_pkg::ANGLE_W-1:0]       angle,
	output logic                               busy,
	output logic signed [TRIG_FRAC_BITS+1:0]   cos_out,
	output logic signed [TRIG_FRAC_BITS+1:0]   sin_out
);

	import srst_pkg::*;

	localparam int TW    = TRIG_FRAC_BITS + 2;
	localparam int XW    = CORDIC_FRAC + 4;
	localparam int SW    = $clog2(CORDIC_STEPS);
	localparam int SH    = CORDIC_FRAC - TRIG_FRAC_BITS;
	localparam int RW    = XW - SH;
	localparam logic signed [RW-1:0] ONE_R  = RW'(1) << TRIG_FRAC_BITS;
	localparam logic signed [XW-1:0] HALF_X = XW'(1) << (SH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ITER,
		ST_ROUND,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [XW-1:0] z_q;
	logic [SW-1:0]        step_q;
	logic                 flip_q;
	logic signed [RW-1:0] xr_q;
	logic signed [RW-1:0] yr_q;
	logic signed [TW-1:0] cos_q;
	logic signed [TW-1:0] sin_q;

	logic                 flip_in;
	logic signed [XW-1:0] z_init;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [XW-1:0] at;
	logic signed [XW-1:0] x_sum;
	logic signed [XW-1:0] y_sum;
	logic signed [RW-1:0] xn;
	logic signed [RW-1:0] yn;
	logic signed [RW-1:0] xc;
	logic signed [RW-1:0] yc;

	// second and third quadrant: add half a turn, negate at the end
	assign flip_in = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
	assign z_init  = XW'($signed({angle[ANGLE_W-1] ^ flip_in, angle[ANGLE_W-2:0],
		{(32 - ANGLE_W){1'b0}}}));

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = XW'($signed({1'b0, atan_turn(5'(step_q))}));

	assign x_sum = x_q + HALF_X;
	assign y_sum = y_q + HALF_X;

	assign xn = flip_q ? -xr_q : xr_q;
	assign yn = flip_q ? -yr_q : yr_q;
	assign xc = (xn > ONE_R) ? ONE_R : ((xn < -ONE_R) ? -ONE_R : xn);
	assign yc = (yn > ONE_R) ? ONE_R : ((yn < -ONE_R) ? -ONE_R : yn);

	assign busy    = (state_q != ST_IDLE);
	assign cos_out = cos_q;
	assign sin_out = sin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			step_q  <= '0;
			flip_q  <= 1'b0;
			xr_q    <= '0;
			yr_q    <= '0;
			cos_q   <= TW'(1) << TRIG_FRAC_BITS;
			sin_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						x_q     <= XW'(CORDIC_GAIN);
						y_q     <= '0;
						z_q     <= z_init;
						flip_q  <= flip_in;
						step_q  <= '0;
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					if (!z_q[XW-1]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end
					if (step_q == SW'(CORDIC_STEPS - 1)) begin
						state_q <= ST_ROUND;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ROUND: begin
					// round half up to the output fraction
					xr_q    <= x_sum[XW-1:SH];
					yr_q    <= y_sum[XW-1:SH];
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					cos_q   <= xc[TW-1:0];
					sin_q   <= yc[TW-1:0];
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/srst_back.sv =====
// ----------------------------------------------------------------------------
// srst_back
// five-stage datapath: rotate, sum, scale, truncate, offset and clamp
// ----------------------------------------------------------------------------
module srst_back #(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 issue,
	input  srst_pkg::item_t                      item,
	input  logic signed [TRIG_FRAC_BITS+1:0]     cos_val,
	input  logic signed [TRIG_FRAC_BITS+1:0]     sin_val,
	input  logic [srst_pkg::SCALE_W-1:0]         scale,
	input  logic signed [srst_pkg::SCREEN_W-1:0] off_x,
	input  logic signed [srst_pkg::SCREEN_W-1:0] off_y,
	output logic                                 res_valid,
	output srst_pkg::result_t                    res
);

	import srst_pkg::*;

	localparam int LANES = 4;
	localparam int DROP  = TRIG_FRAC_BITS + 8;
	localparam int PRW   = TRIG_FRAC_BITS + 10;
	localparam int SCW   = PRW + SCALE_W + 1;
	localparam int QW    = SCW - DROP;
	localparam int SUMW  = QW + 1;
	localparam logic signed [SCW-1:0]  BIAS  = {{(SCW - DROP){1'b0}}, {DROP{1'b1}}};
	localparam logic signed [SUMW-1:0] MAX_S = SUMW'(SCREEN_MAX);
	localparam logic signed [SUMW-1:0] MIN_S = SUMW'(SCREEN_MIN);

	logic signed [COORD_W-1:0] px   [2];
	logic signed [COORD_W-1:0] py   [2];
	logic signed [PRW-1:0]     pa_s1 [LANES];
	logic signed [PRW-1:0]     pb_s1 [LANES];
	logic signed [PRW-1:0]     r_s2  [LANES];
	logic signed [SCW-1:0]     sc_s3 [LANES];
	logic signed [QW-1:0]      q_s4  [LANES];
	logic signed [SCREEN_W-1:0] o_s5 [LANES];
	logic [4:0]                v_q;
	logic [4:0]                last_q;

	assign px[0] = item.start_x;
	assign py[0] = item.start_y;
	assign px[1] = item.end_x;
	assign py[1] = item.end_y;

	// lanes: start x, start y, end x, end y
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		localparam int EP   = k / 2;
		localparam bit IS_Y = (k % 2) == 1;

		logic signed [COORD_W-1:0]  ca;
		logic signed [COORD_W-1:0]  cb;
		logic signed [SCW-1:0]      biased;
		logic signed [SCREEN_W-1:0] off;
		logic signed [SUMW-1:0]     sum;

		assign ca     = IS_Y ? py[EP] : px[EP];
		assign cb     = IS_Y ? px[EP] : py[EP];
		assign biased = sc_s3[k] + (sc_s3[k][SCW-1] ? BIAS : '0);
		assign off    = IS_Y ? off_y : off_x;
		assign sum    = SUMW'(q_s4[k]) + SUMW'(off);

		always_ff @(posedge clk) begin
			pa_s1[k] <= PRW'(ca) * PRW'(cos_val);
			pb_s1[k] <= PRW'(cb) * PRW'(sin_val);
			r_s2[k]  <= IS_Y ? (pa_s1[k] + pb_s1[k]) : (pa_s1[k] - pb_s1[k]);
			sc_s3[k] <= SCW'(r_s2[k]) * SCW'($signed({1'b0, scale}));
			// toward zero: bias negatives before dropping the fraction
			q_s4[k]  <= biased[SCW-1:DROP];
			o_s5[k]  <= (sum > MAX_S) ? SCREEN_MAX :
				((sum < MIN_S) ? SCREEN_MIN : sum[SCREEN_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		last_q <= {last_q[3:0], item.final_line};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[3:0], issue};
		end
	end

	assign res_valid          = v_q[4];
	assign res.screen_start_x = o_s5[0];
	assign res.screen_start_y = o_s5[1];
	assign res.screen_end_x   = o_s5[2];
	assign res.screen_end_y   = o_s5[3];
	assign res.last_out       = last_q[4];

endmodule

// ===== rtl/sprite_rotate_scale_translate.sv =====
// ----------------------------------------------------------------------------
// sprite_rotate_scale_translate
// rotates, scales and places vector sprite lines on a 12-bit screen
// ----------------------------------------------------------------------------
//  channel   handshake                 word
//  -------   -----------------------   -----------------------------------
//  input     push / full               start_x start_y end_x end_y final_line
//  result    pop / empty               screen_* coordinates, last_out
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one line word is taken every clock while full is low; a word that leaves
//  the input queue passes the five-stage datapath into the result queue
//  an angle write runs the shared cordic through its iterations, rounding
//  and finish, during which cfg_ready and the input side hold off (full high)
//  after reset the trig registers hold cosine one and sine zero, scale 1.0
//  a stalled result side fills the result queue; a credit count stops issue
//  before it overflows, then the input queue backs up to full
// ----------------------------------------------------------------------------
module sprite_rotate_scale_translate #(
	parameter int TRIG_FRAC_BITS = 14,
	parameter int CORDIC_STEPS   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// line input
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [srst_pkg::COORD_W-1:0]  start_x,
	input  logic signed [srst_pkg::COORD_W-1:0]  start_y,
	input  logic signed [srst_pkg::COORD_W-1:0]  end_x,
	input  logic signed [srst_pkg::COORD_W-1:0]  end_y,
	input  logic                                 final_line,
	// results
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [srst_pkg::SCREEN_W-1:0] screen_start_x,
	output logic signed [srst_pkg::SCREEN_W-1:0] screen_start_y,
	output logic signed [srst_pkg::SCREEN_W-1:0] screen_end_x,
	output logic signed [srst_pkg::SCREEN_W-1:0] screen_end_y,
	output logic                                 last_out,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [srst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srst_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import srst_pkg::*;

	localparam int TW     = TRIG_FRAC_BITS + 2;
	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(result_t);
	localparam int CRED_W = $clog2(OUT_DEPTH + 1);

	logic                        trig_busy;
	logic                        angle_wr;
	logic                        cfg_fire;
	logic signed [TW-1:0]        cos_val;
	logic signed [TW-1:0]        sin_val;
	logic [SCALE_W-1:0]          scale_q;
	logic signed [SCREEN_W-1:0]  off_x_q;
	logic signed [SCREEN_W-1:0]  off_y_q;

	item_t                       in_item;
	item_t                       head_item;
	logic [ITEM_W-1:0]           head_bits;
	logic                        in_full;
	logic                        in_empty;
	logic                        in_wr;
	logic                        issue;

	logic                        res_valid;
	result_t                     res_word;
	result_t                     out_word;
	logic [RES_W-1:0]            out_bits;
	logic                        out_rd;
	logic [CRED_W-1:0]           credit_q;

	// configuration: only taken when the cordic is free
	assign cfg_ready = !trig_busy;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign angle_wr  = cfg_fire && (cfg_index == REG_ROTATION_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			off_x_q <= '0;
			off_y_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_SCALE_FACTOR: scale_q <= cfg_data[SCALE_W-1:0];
				REG_OFFSET_X:     off_x_q <= cfg_data[SCREEN_W-1:0];
				REG_OFFSET_Y:     off_y_q <= cfg_data[SCREEN_W-1:0];
				// angle goes straight to the cordic; other indexes are ignored
				default: ;
			endcase
		end
	end

	srst_cordic #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS),
		.CORDIC_STEPS  (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (angle_wr),
		.angle  (cfg_data[ANGLE_W-1:0]),
		.busy   (trig_busy),
		.cos_out(cos_val),
		.sin_out(sin_val)
	);

	// front: input queue, held off while the trig values are being rebuilt
	assign in_item.start_x    = start_x;
	assign in_item.start_y    = start_y;
	assign in_item.end_x      = end_x;
	assign in_item.end_y      = end_y;
	assign in_item.final_line = final_line;

	assign full  = in_full || trig_busy;
	assign in_wr = push && !full;

	srst_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(IN_DEPTH)
	) u_in_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (in_wr),
		.wr_data(in_item),
		.rd_en  (issue),
		.rd_data(head_bits),
		.full   (in_full),
		.empty  (in_empty)
	);

	assign head_item = item_t'(head_bits);

	// credits cover words in the datapath plus words in the result queue
	assign issue = !in_empty && (credit_q < CRED_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (issue && !out_rd) begin
			credit_q <= credit_q + 1'b1;
		end else if (out_rd && !issue) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	// back: transform datapath
	srst_back #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.item     (head_item),
		.cos_val  (cos_val),
		.sin_val  (sin_val),
		.scale    (scale_q),
		.off_x    (off_x_q),
		.off_y    (off_y_q),
		.res_valid(res_valid),
		.res      (res_word)
	);

	// result queue
	assign out_rd = pop && !empty;

	srst_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_valid),
		.wr_data(res_word),
		.rd_en  (out_rd),
		.rd_data(out_bits),
		.full   (),
		.empty  (empty)
	);

	assign out_word       = result_t'(out_bits);
	assign screen_start_x = out_word.screen_start_x;
	assign screen_start_y = out_word.screen_start_y;
	assign screen_end_x   = out_word.screen_end_x;
	assign screen_end_y   = out_word.screen_end_y;
	assign last_out       = out_word.last_out;

endmodule
